// ===== rtl/amqpfd_pkg.sv =====
// shared types and constants of the amqp frame deframer
`default_nettype none

package amqpfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CHAN_W   = 16;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HCNT_W   = 3;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [HCNT_W-1:0] HDR_LAST_IDX = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_END_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER  = 8'd1;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 32'd131072;
    localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'd206;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_END     = 4'b0100,
        PH_ERROR   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
        logic                payload_last;
        logic [BYTE_W-1:0]   frame_type;
        logic [CHAN_W-1:0]   channel;
        logic [LEN_W-1:0]    payload_length;
        logic                header_done;
        logic                frame_done;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/amqpfd_parser.sv =====
// input register, config registers and frame parsing state machine
`default_nettype none

module amqpfd_parser
    import amqpfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output result_t                   res
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [LEN_W-1:0]  max_payload_reg;
    logic [BYTE_W-1:0] end_marker_reg;

    phase_t            phase_reg, phase_next;
    logic [HCNT_W-1:0] header_count_reg, header_count_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [CHAN_W-1:0] channel_reg, channel_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;

    logic step;

    assign cfg_ready = 1'b1;
    assign res_valid = in_vld_reg;
    assign step      = in_vld_reg && res_ready;
    assign s_ready   = !in_vld_reg || res_ready;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            end_marker_reg  <= END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MAX_PAYLOAD) begin
                max_payload_reg <= cfg_data;
            end else if (cfg_index == REG_END_MARKER) begin
                end_marker_reg <= cfg_data[BYTE_W-1:0];
            end
        end
    end

    // next state and result for the request in the input stage
    always_comb begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        type_next         = type_reg;
        channel_next      = channel_reg;
        length_next       = length_reg;
        bytes_left_next   = bytes_left_reg;

        res.payload_byte  = '0;
        res.payload_valid = 1'b0;
        res.payload_last  = 1'b0;
        res.header_done   = 1'b0;
        res.frame_done    = 1'b0;
        res.status        = STATUS_OK;

        case (phase_reg)
            PH_HEADER: begin
                if (header_count_reg == 3'd0) begin
                    type_next = in_byte_reg;
                end else if (header_count_reg inside {3'd1, 3'd2}) begin
                    channel_next = {channel_reg[CHAN_W-BYTE_W-1:0], in_byte_reg};
                end else begin
                    length_next = {length_reg[LEN_W-BYTE_W-1:0], in_byte_reg};
                end
                if (header_count_reg >= HDR_LAST_IDX) begin
                    header_count_next = '0;
                    if (length_next > max_payload_reg) begin
                        res.status = STATUS_LEN_ERR;
                        phase_next = PH_ERROR;
                    end else begin
                        res.header_done = 1'b1;
                        bytes_left_next = length_next;
                        phase_next      = (length_next == '0) ? PH_END : PH_PAYLOAD;
                    end
                end else begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                res.payload_byte  = in_byte_reg;
                res.payload_valid = 1'b1;
                if (bytes_left_reg <= 32'd1) begin
                    bytes_left_next  = '0;
                    res.payload_last = 1'b1;
                    phase_next       = PH_END;
                end else begin
                    bytes_left_next = bytes_left_reg - 32'd1;
                end
            end
            PH_END: begin
                if (in_byte_reg == end_marker_reg) begin
                    res.frame_done    = 1'b1;
                    phase_next        = PH_HEADER;
                    header_count_next = '0;
                end else begin
                    res.status = STATUS_END_ERR;
                    phase_next = PH_ERROR;
                end
            end
            default: begin
                res.status = STATUS_DROPPED;
            end
        endcase

        res.frame_type     = type_next;
        res.channel        = channel_next;
        res.payload_length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            type_reg         <= '0;
            channel_reg      <= '0;
            length_reg       <= '0;
            bytes_left_reg   <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            type_reg         <= type_next;
            channel_reg      <= channel_next;
            length_reg       <= length_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    // error phase is sticky until reset
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("left error phase without reset");

    // header counter stays within the seven header bytes
    a_hcount_range: assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg <= HDR_LAST_IDX)
        else $error("header count out of range");

    // payload phase always has at least one byte outstanding
    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    // a completed header moves on to payload or end marker
    a_hdr_done_next: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.header_done |=> (phase_reg == PH_PAYLOAD || phase_reg == PH_END))
        else $error("header done without frame body phase");

endmodule

`default_nettype wire

// ===== rtl/amqpfd_out_reg.sv =====
// result register of the deframer with valid/ready handshake
`default_nettype none

module amqpfd_out_reg
    import amqpfd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    logic    out_vld_reg;
    result_t out_data_reg;

    assign res_ready = !out_vld_reg || m_ready;
    assign m_valid   = out_vld_reg;
    assign m_res     = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_ready) begin
            out_vld_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/amqp_frame_deframer_core.sv =====
// amqp frame deframer top level
// input stage and result register lie between s_data_byte and the m_ports
// throughput: one byte per clock; input stage and result register each hand over
// in the cycle they are emptied, so back-pressure stalls without bubbles
// reset (aresetn low, synchronous): header phase, counters and header fields cleared,
// max_payload 131072 and end_marker 206, both channels empty
`default_nettype none

module amqp_frame_deframer_core
    import amqpfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BYTE_W-1:0]         m_payload_byte,
    output logic                      m_payload_valid,
    output logic                      m_payload_last,
    output logic [BYTE_W-1:0]         m_frame_type,
    output logic [CHAN_W-1:0]         m_channel,
    output logic [LEN_W-1:0]          m_payload_length,
    output logic                      m_header_done,
    output logic                      m_frame_done,
    output logic [STATUS_W-1:0]       m_status,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t m_res;

    amqpfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    amqpfd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_payload_byte   = m_res.payload_byte;
    assign m_payload_valid  = m_res.payload_valid;
    assign m_payload_last   = m_res.payload_last;
    assign m_frame_type     = m_res.frame_type;
    assign m_channel        = m_res.channel;
    assign m_payload_length = m_res.payload_length;
    assign m_header_done    = m_res.header_done;
    assign m_frame_done     = m_res.frame_done;
    assign m_status         = m_res.status;

endmodule

`default_nettype wire
